>>> rtl/bpa_pkg.sv
// Shared types and constants of the buddy page allocator.
// Used by the channel interfaces, the top level and the port checker.
`default_nettype none

package bpa_pkg;

    // Pages in the largest pool; the page and count fields are sized for it.
    localparam int MAX_PAGES  = 4096;

    // Field widths of the request and response words.
    localparam int OP_W       = 1;
    localparam int ORDER_W    = 4;
    localparam int PAGE_W     = 12;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 13;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Register index, taken from byte address bit 2.
    localparam logic REG_POOL_PAGES = 1'b0;

    typedef logic [ORDER_W-1:0] order_t;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOMEM    = 3'd1,
        ST_ORDER    = 3'd2,
        ST_NOTALLOC = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // Per-page entry: chunk order and allocated mark.
    typedef struct packed {
        order_t order;
        logic   mark;
    } page_word_t;

endpackage

`default_nettype wire

>>> rtl/bpa_ifs.sv
// Request and response channel interfaces of the buddy page allocator.
// Depends on bpa_pkg for field types.
`default_nettype none

// Request channel: one allocate or free request per word.
interface bpa_req_if;
    logic                         valid;
    logic                         ready;
    bpa_pkg::op_t                 op;
    bpa_pkg::order_t              order;
    logic [bpa_pkg::PAGE_W-1:0]   page_index;

    modport source (output valid, output op, output order, output page_index, input ready);
    modport sink   (input valid, input op, input order, input page_index, output ready);
endinterface

// Response channel: one result word per request.
interface bpa_rsp_if;
    logic                         valid;
    logic                         ready;
    bpa_pkg::status_t             status;
    logic [bpa_pkg::PAGE_W-1:0]   result_page;
    bpa_pkg::order_t              result_order;
    logic [bpa_pkg::COUNT_W-1:0]  free_count;

    modport source (output valid, output status, output result_page, output result_order,
                    output free_count, input ready);
    modport sink   (input valid, input status, input result_page, input result_order,
                    input free_count, output ready);
endinterface

`default_nettype wire

>>> rtl/bpa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; a read of the address being written returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/buddy_page_allocator_unit.sv
// Buddy page allocator: top level with configuration port, sequencer and state memories.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if and bpa_ram.
`default_nettype none

// The allocator serves one request at a time; the request port is ready only while the
// sequencer is idle, and a finished word waits in an output register so the next request
// can enter meanwhile. Per-page order and mark live in one RAM and the free-list links in
// another, both with a registered read port, so every step costs a read and a write-back.
// An allocate walks the list search one order per cycle, then splits, pushing the upper
// buddy onto its list when it lies in the pool, then marks the returned pages one page per
// cycle. A free runs a check pass and a clear pass over the pages of its chunk, merges with
// free buddies and finally pushes the merged chunk. Order and range errors go straight from
// idle to the result, out of memory after the search, and a not-allocated error once the
// head page's order does not fit or the check pass meets a free page. After reset and
// after every write of pool_pages, a clearing pass initializes the page RAM; requests
// are held off during it, and the host then frees every page to fill the pool.
module buddy_page_allocator_unit #(
    parameter int MAX_ORDER = 11
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    bpa_req_if.sink                                 req,
    bpa_rsp_if.source                               rsp,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bpa_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [bpa_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [bpa_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                    pready
);

    import bpa_pkg::*;

    localparam int IW  = $clog2(MAX_PAGES);
    localparam int LW  = IW + 1;
    localparam int PLW = $clog2(MAX_PAGES + 1);
    localparam int XW  = ((IW > 16) ? IW : 16) + 2;
    localparam int OIW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    localparam logic [LW-1:0] LINK_NONE = LW'(MAX_PAGES);

    typedef struct packed {
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } link_word_t;

    typedef enum logic [19:0] {
        S_CLEAR   = 20'h00001,
        S_IDLE    = 20'h00002,
        S_SEARCH  = 20'h00004,
        S_SPLIT   = 20'h00008,
        S_AMARK   = 20'h00010,
        S_FHEAD   = 20'h00020,
        S_FCHK    = 20'h00040,
        S_FCLR    = 20'h00080,
        S_MTEST   = 20'h00100,
        S_MCHK    = 20'h00200,
        S_MJOIN_B = 20'h00400,
        S_MJOIN_C = 20'h00800,
        S_MFIN    = 20'h01000,
        S_ULINK0  = 20'h02000,
        S_ULINK1  = 20'h04000,
        S_ULINK2  = 20'h08000,
        S_ULINK3  = 20'h10000,
        S_PUSH0   = 20'h20000,
        S_PUSH1   = 20'h40000,
        S_DONE    = 20'h80000
    } state_t;

    // Control registers.
    state_t            state_reg, state_next;
    logic [XW-1:0]     i_reg, i_next;
    logic [PLW-1:0]    pool_reg, pool_next;
    logic [PLW-1:0]    free_reg, free_next;
    logic [LW-1:0]     head_reg [MAX_ORDER];
    logic [LW-1:0]     head_next [MAX_ORDER];
    logic              out_valid_reg, out_valid_next;

    // Working registers of the current request.
    state_t            ret_reg, ret_next;
    order_t            k_reg, k_next;
    logic [IW-1:0]     c_reg, c_next;
    logic [IW-1:0]     b_reg, b_next;
    logic [IW-1:0]     p_reg, p_next;
    logic [LW-1:0]     pv_reg, pv_next;
    logic [LW-1:0]     nx_reg, nx_next;
    order_t            req_order_reg, req_order_next;
    logic [PAGE_W-1:0] req_page_reg, req_page_next;
    status_t           res_status_reg, res_status_next;
    logic [PAGE_W-1:0] res_page_reg, res_page_next;
    order_t            res_order_reg, res_order_next;

    // Output word register.
    status_t            out_status_reg, out_status_next;
    logic [PAGE_W-1:0]  out_page_reg, out_page_next;
    order_t             out_order_reg, out_order_next;
    logic [COUNT_W-1:0] out_free_reg, out_free_next;

    // Memory ports.
    logic              pr_we;
    logic [IW-1:0]     pr_waddr, pr_raddr;
    page_word_t        pr_wdata, pr_rdata;
    logic              lr_we;
    logic [IW-1:0]     lr_waddr, lr_raddr;
    link_word_t        lr_wdata, lr_rdata;

    // Helpers.
    logic              cfg_wr;
    logic [LW-1:0]     head_k;
    logic [XW-1:0]     pow_k;
    logic [XW-1:0]     size_req;
    logic [XW-1:0]     addr_c;
    logic [XW-1:0]     addr_p;
    logic [XW-1:0]     bx;
    logic [XW-1:0]     pool_x;
    logic [XW-1:0]     free_x;
    order_t            k_dec;
    logic [XW-1:0]     b_split;

    // Order and mark per page.
    bpa_ram #(.WIDTH($bits(page_word_t)), .DEPTH(MAX_PAGES)) u_page_ram (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .raddr (pr_raddr),
        .rdata (pr_rdata)
    );

    // Next and previous links of the free lists.
    bpa_ram #(.WIDTH($bits(link_word_t)), .DEPTH(MAX_PAGES)) u_link_ram (
        .clk   (clk),
        .we    (lr_we),
        .waddr (lr_waddr),
        .wdata (lr_wdata),
        .raddr (lr_raddr),
        .rdata (lr_rdata)
    );

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POOL_PAGES);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POOL_PAGES) ? CFG_DATA_W'(pool_reg) : '0;

    // Channel outputs.
    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.result_page  = out_page_reg;
    assign rsp.result_order = out_order_reg;
    assign rsp.free_count   = out_free_reg;

    // Shared arithmetic of the sequencer.
    assign head_k   = head_reg[k_reg[OIW-1:0]];
    assign pow_k    = XW'(1) << k_reg;
    assign size_req = XW'(1) << req_order_reg;
    assign addr_c   = XW'(c_reg) + i_reg;
    assign addr_p   = XW'(req_page_reg) + i_reg;
    assign bx       = XW'(c_reg) ^ pow_k;
    assign pool_x   = XW'(pool_reg);
    assign free_x   = XW'(free_reg);
    assign k_dec    = k_reg - order_t'(1);
    assign b_split  = XW'(c_reg) + (XW'(1) << k_dec);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        pool_next       = pool_reg;
        free_next       = free_reg;
        head_next       = head_reg;
        out_valid_next  = out_valid_reg;
        ret_next        = ret_reg;
        k_next          = k_reg;
        c_next          = c_reg;
        b_next          = b_reg;
        p_next          = p_reg;
        pv_next         = pv_reg;
        nx_next         = nx_reg;
        req_order_next  = req_order_reg;
        req_page_next   = req_page_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_order_next  = res_order_reg;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;
        out_order_next  = out_order_reg;
        out_free_next   = out_free_reg;
        pr_we           = 1'b0;
        pr_waddr        = '0;
        pr_wdata        = '0;
        pr_raddr        = '0;
        lr_we           = 1'b0;
        lr_waddr        = '0;
        lr_wdata        = '0;
        lr_raddr        = '0;

        // The output word leaves when taken.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            // Sweep the page RAM to order 0, allocated.
            S_CLEAR:
            begin
                pr_we    = 1'b1;
                pr_waddr = IW'(i_reg);
                pr_wdata = '{order: '0, mark: 1'b1};
                if (i_reg == XW'(MAX_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next = i_reg + XW'(1);
                end
            end

            // Take a request and check its order or page range.
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_order_next = req.order;
                    req_page_next  = req.page_index;
                    if (req.op == OP_ALLOC)
                    begin
                        if (5'(req.order) >= 5'(MAX_ORDER))
                        begin
                            res_status_next = ST_ORDER;
                            res_page_next   = '0;
                            res_order_next  = req.order;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            k_next     = req.order;
                            state_next = S_SEARCH;
                        end
                    end
                    else if (XW'(req.page_index) >= pool_x)
                    begin
                        res_status_next = ST_RANGE;
                        res_page_next   = '0;
                        res_order_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        pr_raddr   = IW'(req.page_index);
                        state_next = S_FHEAD;
                    end
                end
            end

            // Walk up the orders to the first non-empty list.
            S_SEARCH:
            begin
                if (head_k < LINK_NONE)
                begin
                    c_next     = IW'(head_k);
                    p_next     = IW'(head_k);
                    lr_raddr   = IW'(head_k);
                    ret_next   = S_SPLIT;
                    state_next = S_ULINK0;
                end
                else if (5'(k_reg) + 5'd1 >= 5'(MAX_ORDER))
                begin
                    res_status_next = ST_NOMEM;
                    res_page_next   = '0;
                    res_order_next  = req_order_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    k_next = k_reg + order_t'(1);
                end
            end

            // Unlink, step 1: links of the removed chunk have arrived.
            S_ULINK0:
            begin
                pv_next = lr_rdata.prv;
                nx_next = lr_rdata.nxt;
                if (lr_rdata.prv < LINK_NONE)
                begin
                    lr_raddr   = IW'(lr_rdata.prv);
                    state_next = S_ULINK1;
                end
                else
                begin
                    head_next[k_reg[OIW-1:0]] = (lr_rdata.nxt < LINK_NONE) ? lr_rdata.nxt
                                                                           : LINK_NONE;
                    state_next = S_ULINK2;
                end
            end

            // Unlink, step 2: point the predecessor past the chunk.
            S_ULINK1:
            begin
                lr_we      = 1'b1;
                lr_waddr   = IW'(pv_reg);
                lr_wdata   = '{nxt: nx_reg, prv: lr_rdata.prv};
                state_next = S_ULINK2;
            end

            // Unlink, step 3: fetch the successor if there is one.
            S_ULINK2:
            begin
                if (nx_reg < LINK_NONE)
                begin
                    lr_raddr   = IW'(nx_reg);
                    state_next = S_ULINK3;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end

            // Unlink, step 4: point the successor back past the chunk.
            S_ULINK3:
            begin
                lr_we      = 1'b1;
                lr_waddr   = IW'(nx_reg);
                lr_wdata   = '{nxt: lr_rdata.nxt, prv: pv_reg};
                state_next = ret_reg;
            end

            // Push, step 1: new head links to the old head.
            S_PUSH0:
            begin
                lr_we    = 1'b1;
                lr_waddr = p_reg;
                lr_wdata = '{nxt: head_k, prv: LINK_NONE};
                head_next[k_reg[OIW-1:0]] = LW'(p_reg);
                if (head_k < LINK_NONE)
                begin
                    nx_next    = head_k;
                    lr_raddr   = IW'(head_k);
                    state_next = S_PUSH1;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end

            // Push, step 2: old head links back to the new one.
            S_PUSH1:
            begin
                lr_we      = 1'b1;
                lr_waddr   = IW'(nx_reg);
                lr_wdata   = '{nxt: lr_rdata.nxt, prv: LW'(p_reg)};
                state_next = ret_reg;
            end

            // Halve the chunk, freeing the upper buddy when it lies in the pool.
            S_SPLIT:
            begin
                if (k_reg > req_order_reg)
                begin
                    k_next = k_dec;
                    if (b_split < pool_x)
                    begin
                        pr_we      = 1'b1;
                        pr_waddr   = IW'(b_split);
                        pr_wdata   = '{order: k_dec, mark: 1'b0};
                        p_next     = IW'(b_split);
                        ret_next   = S_SPLIT;
                        state_next = S_PUSH0;
                    end
                end
                else
                begin
                    i_next     = '0;
                    pr_raddr   = c_reg;
                    state_next = S_AMARK;
                end
            end

            // Mark the returned pages allocated, one page a cycle.
            S_AMARK:
            begin
                if (addr_c < XW'(MAX_PAGES))
                begin
                    pr_we    = 1'b1;
                    pr_waddr = IW'(addr_c);
                    pr_wdata = '{order: (i_reg == '0) ? req_order_reg : pr_rdata.order,
                                 mark: 1'b1};
                end
                if (i_reg + XW'(1) < size_req)
                begin
                    i_next   = i_reg + XW'(1);
                    pr_raddr = IW'(addr_c + XW'(1));
                end
                else
                begin
                    free_next       = (free_x >= size_req) ? PLW'(free_x - size_req) : '0;
                    res_status_next = ST_OK;
                    res_page_next   = PAGE_W'(c_reg);
                    res_order_next  = req_order_reg;
                    state_next      = S_DONE;
                end
            end

            // Free: chunk order of the head page tells the extent.
            S_FHEAD:
            begin
                if (((XW'(req_page_reg) & ((XW'(1) << pr_rdata.order) - XW'(1))) != '0) ||
                    (XW'(req_page_reg) + (XW'(1) << pr_rdata.order) > pool_x))
                begin
                    res_status_next = ST_NOTALLOC;
                    res_page_next   = '0;
                    res_order_next  = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    k_next     = pr_rdata.order;
                    i_next     = '0;
                    pr_raddr   = IW'(req_page_reg);
                    state_next = S_FCHK;
                end
            end

            // Every page of the chunk must be allocated.
            S_FCHK:
            begin
                if (!pr_rdata.mark)
                begin
                    res_status_next = ST_NOTALLOC;
                    res_page_next   = '0;
                    res_order_next  = '0;
                    state_next      = S_DONE;
                end
                else if (i_reg + XW'(1) < pow_k)
                begin
                    i_next   = i_reg + XW'(1);
                    pr_raddr = IW'(addr_p + XW'(1));
                end
                else
                begin
                    i_next     = '0;
                    pr_raddr   = IW'(req_page_reg);
                    state_next = S_FCLR;
                end
            end

            // Clear the marks, keeping each page's order.
            S_FCLR:
            begin
                pr_we    = 1'b1;
                pr_waddr = IW'(addr_p);
                pr_wdata = '{order: pr_rdata.order, mark: 1'b0};
                if (i_reg + XW'(1) < pow_k)
                begin
                    i_next   = i_reg + XW'(1);
                    pr_raddr = IW'(addr_p + XW'(1));
                end
                else
                begin
                    free_next  = PLW'(free_x + pow_k);
                    c_next     = IW'(req_page_reg);
                    state_next = S_MTEST;
                end
            end

            // Merge test: buddy must lie in the pool and the order have room to grow.
            S_MTEST:
            begin
                if ((5'(k_reg) + 5'd1 < 5'(MAX_ORDER)) && (bx + pow_k <= pool_x))
                begin
                    b_next     = IW'(bx);
                    pr_raddr   = IW'(bx);
                    state_next = S_MCHK;
                end
                else
                begin
                    state_next = S_MFIN;
                end
            end

            // Buddy must be a free chunk of the same order.
            S_MCHK:
            begin
                if (pr_rdata.mark || (pr_rdata.order != k_reg))
                begin
                    state_next = S_MFIN;
                end
                else
                begin
                    p_next     = b_reg;
                    lr_raddr   = b_reg;
                    ret_next   = S_MJOIN_B;
                    state_next = S_ULINK0;
                end
            end

            // Raise the order of both halves.
            S_MJOIN_B:
            begin
                pr_we      = 1'b1;
                pr_waddr   = b_reg;
                pr_wdata   = '{order: k_reg + order_t'(1), mark: 1'b0};
                state_next = S_MJOIN_C;
            end

            S_MJOIN_C:
            begin
                pr_we    = 1'b1;
                pr_waddr = c_reg;
                pr_wdata = '{order: k_reg + order_t'(1), mark: 1'b0};
                if (b_reg < c_reg)
                begin
                    c_next = b_reg;
                end
                k_next     = k_reg + order_t'(1);
                state_next = S_MTEST;
            end

            // Settle the merged chunk and push it.
            S_MFIN:
            begin
                pr_we           = 1'b1;
                pr_waddr        = c_reg;
                pr_wdata        = '{order: k_reg, mark: 1'b0};
                p_next          = c_reg;
                res_status_next = ST_OK;
                res_page_next   = PAGE_W'(c_reg);
                res_order_next  = k_reg;
                ret_next        = S_DONE;
                state_next      = S_PUSH0;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_page_next   = res_page_reg;
                    out_order_next  = res_order_reg;
                    out_free_next   = COUNT_W'(free_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
                i_next     = '0;
            end
        endcase

        // A pool size write restarts the clearing pass and empties the free lists and count.
        if (cfg_wr)
        begin
            pool_next  = (pwdata > CFG_DATA_W'(MAX_PAGES)) ? PLW'(MAX_PAGES) : PLW'(pwdata);
            free_next  = '0;
            i_next     = '0;
            state_next = S_CLEAR;
            for (int n = 0; n < MAX_ORDER; n++)
            begin
                head_next[n] = LINK_NONE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            i_reg         <= '0;
            pool_reg      <= PLW'(MAX_PAGES);
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int n = 0; n < MAX_ORDER; n++)
            begin
                head_reg[n] <= LINK_NONE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            pool_reg      <= pool_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        ret_reg        <= ret_next;
        k_reg          <= k_next;
        c_reg          <= c_next;
        b_reg          <= b_next;
        p_reg          <= p_next;
        pv_reg         <= pv_next;
        nx_reg         <= nx_next;
        req_order_reg  <= req_order_next;
        req_page_reg   <= req_page_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_order_reg  <= res_order_next;
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
        out_order_reg  <= out_order_next;
        out_free_reg   <= out_free_next;
    end

endmodule

`default_nettype wire

>>> rtl/bpa_checker.sv
// Port-level checker of the buddy page allocator, bound to the top level.
// Depends on bpa_pkg for status codes, field widths and the page limit.
`default_nettype none

module bpa_checker #(
    parameter int MAX_ORDER = 11
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    input  wire logic                             req_ready,
    input  wire logic                             rsp_valid,
    input  wire logic                             rsp_ready,
    input  wire logic [bpa_pkg::STATUS_W-1:0]     rsp_status,
    input  wire logic [bpa_pkg::PAGE_W-1:0]       rsp_result_page,
    input  wire logic [bpa_pkg::ORDER_W-1:0]      rsp_result_order,
    input  wire logic [bpa_pkg::COUNT_W-1:0]      rsp_free_count
);

    import bpa_pkg::*;

    logic       req_fire;
    logic       rsp_fire;
    logic [1:0] pending_reg, pending_next;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Words accepted and not yet answered.
    always_comb
    begin
        pending_next = pending_reg + 2'(req_fire) - 2'(rsp_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Every response answers an earlier request.
    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire |-> (pending_reg != 2'd0))
        else $error("response without a pending request");

    // At most one request in work plus one answer waiting.
    a_req_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |-> (pending_reg < 2'd2))
        else $error("request taken while two are outstanding");

    // Failures carry no page, and their free count never exceeds MAX_PAGES.
    a_fail_no_page: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status != ST_OK)) |->
            ((rsp_result_page == '0) && (32'(rsp_free_count) <= MAX_PAGES)))
        else $error("failed response carries a page or bad free count");

    // An order error echoes an order at or above the limit.
    a_order_err: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_ORDER)) |-> (5'(rsp_result_order) >= 5'(MAX_ORDER)))
        else $error("order error on an order within range");

    // A stalled response word holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_status) && $stable(rsp_result_page) &&
             $stable(rsp_result_order) && $stable(rsp_free_count)))
        else $error("stalled response changed");

endmodule

bind buddy_page_allocator_unit bpa_checker #(
    .MAX_ORDER (MAX_ORDER)
) u_bpa_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_result_page  (rsp.result_page),
    .rsp_result_order (rsp.result_order),
    .rsp_free_count   (rsp.free_count)
);

`default_nettype wire
